>>> rtl/prq_pkg.sv
// shared constants and types for the priority request queue
// no dependencies
package prq_pkg;

  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned IdW = 64;
  localparam int unsigned KindW = 8;
  localparam int unsigned PrioW = 8;
  localparam int unsigned EntryW = IdW + KindW + PrioW;

  localparam logic [1:0] CmdSubmit = 2'd0;
  localparam logic [1:0] CmdPop = 2'd1;
  localparam logic [1:0] CmdFinish = 2'd2;
  localparam logic [1:0] CmdShutdown = 2'd3;

  localparam logic [1:0] FinOk = 2'd0;
  localparam logic [1:0] FinCancel = 2'd1;

  localparam logic [2:0] StAccepted = 3'd0;
  localparam logic [2:0] StInvalid = 3'd1;
  localparam logic [2:0] StFull = 3'd2;
  localparam logic [2:0] StShutting = 3'd3;
  localparam logic [2:0] StIssued = 3'd4;
  localparam logic [2:0] StEmpty = 3'd5;
  localparam logic [2:0] StFinished = 3'd6;
  localparam logic [2:0] StShutdownDone = 3'd7;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic [KindW-1:0] kind;
    logic [PrioW-1:0] prio;
  } entry_t;

endpackage

>>> rtl/priority_request_queue.sv
// Priority request queue with admission control.
// One command per transaction: submit, pop, finish, shutdown. The receiver cannot stall:
// each result is shown for exactly one cycle with done_o high. Submit, finish and shutdown
// pass through the done state alone, which holds busy, and done_o is registered from it. Pop with
// n pending entries first scans the entry memory one read a cycle for the best priority.
// It then moves each later entry down one place, with a read state and a write state for
// each entry, and last passes through the done state to strobe like the other commands.
// busy is already low in the strobe cycle, so the next command can be accepted at its end.
// Depends on prq_pkg.
module priority_request_queue #(
  parameter int unsigned QUEUE_DEPTH = prq_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  input  logic [1:0]  command_i,
  input  logic [63:0] asset_id_i,
  input  logic [7:0]  asset_kind_i,
  input  logic [7:0]  priority_req_i,
  input  logic [1:0]  finish_status_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [63:0] issued_asset_id_o,
  output logic [7:0]  issued_kind_o,
  output logic [7:0]  issued_priority_o,
  output logic [6:0]  queue_depth_o,
  output logic [15:0] busy_count_o,
  output logic [6:0]  drained_count_o,
  output logic [31:0] total_submitted_o,
  output logic [31:0] total_completed_o,
  output logic [31:0] total_cancelled_o,
  output logic [31:0] total_rejected_full_o,
  output logic [31:0] total_failed_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SScan = 3'd1;
  localparam logic [2:0] SMvRd = 3'd2;
  localparam logic [2:0] SMvWr = 3'd3;
  localparam logic [2:0] SDone = 3'd4;

  prq_pkg::entry_t mem_q [QUEUE_DEPTH];
  prq_pkg::entry_t rdata_q;

  logic [2:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic shut_q, shut_d;
  logic [15:0] busyc_q, busyc_d;
  logic [31:0] sub_q, sub_d, comp_q, comp_d, canc_q, canc_d, full_q, full_d;
  logic [31:0] fail_q, fail_d;
  logic [6:0] maxd_q;

  // scan/move control
  logic [CW-1:0] idx_q, idx_d;      // next address to issue
  logic rvalid_q, rvalid_d;         // read data valid this cycle
  logic [CW-1:0] ridx_q, ridx_d;    // address of rdata_q
  logic [CW-1:0] best_q, best_d;
  prq_pkg::entry_t best_e_q, best_e_d;

  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  prq_pkg::entry_t wr_data;

  logic        done_d;
  logic [2:0]  st_q, st_d;
  prq_pkg::entry_t iss_q, iss_d;
  logic [6:0]  drn_q, drn_d;
  logic        done_q;

  logic [CW-1:0] limit;
  logic [7:0] maxw;

  assign busy = (state_q != SIdle);
  assign cfg_ready_o = (state_q == SIdle) && !start;

  always_comb begin
    maxw = {1'b0, maxd_q};
    if (maxd_q == 7'd0 || 32'(maxw) > QUEUE_DEPTH) begin
      limit = CW'(QUEUE_DEPTH);
    end else begin
      limit = CW'(maxd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    shut_d = shut_q;
    busyc_d = busyc_q;
    sub_d = sub_q;
    comp_d = comp_q;
    canc_d = canc_q;
    full_d = full_q;
    fail_d = fail_q;
    idx_d = idx_q;
    rvalid_d = 1'b0;
    ridx_d = idx_q;
    best_d = best_q;
    best_e_d = best_e_q;
    rd_en = 1'b0;
    rd_addr = idx_q[AW-1:0];
    wr_en = 1'b0;
    wr_addr = count_q[AW-1:0];
    wr_data = '{id: asset_id_i, kind: asset_kind_i, prio: priority_req_i};
    done_d = 1'b0;
    st_d = st_q;
    iss_d = '0;
    drn_d = 7'd0;
    case (state_q)
      SIdle: begin
        if (start) begin
          state_d = SDone;
          case (command_i)
            prq_pkg::CmdSubmit: begin
              if (asset_kind_i == 8'd0 || asset_id_i == 64'd0) begin
                st_d = prq_pkg::StInvalid;
              end else if (shut_q) begin
                st_d = prq_pkg::StShutting;
                fail_d = fail_q + 32'd1;
              end else if (count_q >= limit) begin
                st_d = prq_pkg::StFull;
                full_d = full_q + 32'd1;
              end else begin
                wr_en = 1'b1;
                count_d = count_q + CW'(1);
                sub_d = sub_q + 32'd1;
                st_d = prq_pkg::StAccepted;
              end
            end
            prq_pkg::CmdPop: begin
              if (count_q == '0) begin
                st_d = prq_pkg::StEmpty;
              end else begin
                state_d = SScan;
                rd_en = 1'b1;
                rd_addr = '0;
                idx_d = CW'(1);
                rvalid_d = 1'b1;
                ridx_d = '0;
              end
            end
            prq_pkg::CmdFinish: begin
              if (busyc_q != 16'd0) busyc_d = busyc_q - 16'd1;
              if (finish_status_i == prq_pkg::FinOk) begin
                comp_d = comp_q + 32'd1;
              end else if (finish_status_i == prq_pkg::FinCancel) begin
                canc_d = canc_q + 32'd1;
              end else begin
                fail_d = fail_q + 32'd1;
              end
              st_d = prq_pkg::StFinished;
            end
            default: begin
              if (!shut_q) begin
                shut_d = 1'b1;
                drn_d = 7'(count_q);
                fail_d = fail_q + 32'(count_q);
                count_d = '0;
              end
              st_d = prq_pkg::StShutdownDone;
            end
          endcase
        end
      end
      SScan: begin
        // strict less keeps the oldest on ties
        if (rvalid_q) begin
          if (ridx_q == '0 || rdata_q.prio < best_e_q.prio) begin
            best_d = ridx_q;
            best_e_d = rdata_q;
          end
        end
        if (idx_q < count_q) begin
          rd_en = 1'b1;
          idx_d = idx_q + CW'(1);
          rvalid_d = 1'b1;
        end else if (!rvalid_q) begin
          // best settled, start compaction from best+1
          idx_d = best_q + CW'(1);
          state_d = SMvRd;
        end
      end
      SMvRd: begin
        if (idx_q < count_q) begin
          rd_en = 1'b1;
          state_d = SMvWr;
        end else begin
          count_d = count_q - CW'(1);
          if (busyc_q != 16'hFFFF) busyc_d = busyc_q + 16'd1;
          st_d = prq_pkg::StIssued;
          iss_d = best_e_q;
          state_d = SDone;
        end
      end
      SMvWr: begin
        wr_en = 1'b1;
        wr_addr = AW'(idx_q - CW'(1));
        wr_data = rdata_q;
        idx_d = idx_q + CW'(1);
        state_d = SMvRd;
      end
      SDone: begin
        done_d = 1'b1;
        state_d = SIdle;
        iss_d = iss_q;
        drn_d = drn_q;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      shut_q <= 1'b0;
      busyc_q <= '0;
      sub_q <= '0;
      comp_q <= '0;
      canc_q <= '0;
      full_q <= '0;
      fail_q <= '0;
      maxd_q <= 7'd64;
      rvalid_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      shut_q <= shut_d;
      busyc_q <= busyc_d;
      sub_q <= sub_d;
      comp_q <= comp_d;
      canc_q <= canc_d;
      full_q <= full_d;
      fail_q <= fail_d;
      rvalid_q <= rvalid_d;
      done_q <= done_d;
      if (cfg_valid_i && cfg_ready_o) maxd_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    ridx_q <= ridx_d;
    best_q <= best_d;
    best_e_q <= best_e_d;
    st_q <= st_d;
    iss_q <= iss_d;
    drn_q <= drn_d;
  end

  assign done_o = done_q;
  assign status_o = st_q;
  assign issued_asset_id_o = iss_q.id;
  assign issued_kind_o = iss_q.kind;
  assign issued_priority_o = iss_q.prio;
  assign queue_depth_o = 7'(count_q);
  assign busy_count_o = busyc_q;
  assign drained_count_o = drn_q;
  assign total_submitted_o = sub_q;
  assign total_completed_o = comp_q;
  assign total_cancelled_o = canc_q;
  assign total_rejected_full_o = full_q;
  assign total_failed_o = fail_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= QUEUE_DEPTH) else $error("entry count above capacity");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_no_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !cfg_ready_o) else $error("config ready while busy");
  a_shut_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(shut_q) |-> shut_q) else $error("shutdown flag cleared");

endmodule

>>> tb/sv/priority_request_queue_tb.sv
// testbench for priority_request_queue: directed and random command streams
// checked against a behavioral queue model kept in this file
// depends on prq_pkg and priority_request_queue
module priority_request_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDepth = prq_pkg::QueueDepthDefault;
  localparam logic [1:0] FinFailed = 2'd2;
  localparam logic [1:0] FinUndefined = 2'd3;
  localparam int unsigned RandomItems = 550;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] id;
    logic [7:0]  kind;
    logic [7:0]  prio;
    logic [6:0]  depth;
    logic [15:0] busy_cnt;
    logic [6:0]  drained;
    logic [31:0] submitted;
    logic [31:0] completed;
    logic [31:0] cancelled;
    logic [31:0] rejected_full;
    logic [31:0] failed;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;
  logic [1:0]  command_i = '0;
  logic [63:0] asset_id_i = '0;
  logic [7:0]  asset_kind_i = '0;
  logic [7:0]  priority_req_i = '0;
  logic [1:0]  finish_status_i = '0;
  logic        done_o;
  outcome_t    seen;

  priority_request_queue u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .command_i(command_i), .asset_id_i(asset_id_i), .asset_kind_i(asset_kind_i),
    .priority_req_i(priority_req_i), .finish_status_i(finish_status_i),
    .done_o(done_o), .status_o(seen.status), .issued_asset_id_o(seen.id),
    .issued_kind_o(seen.kind), .issued_priority_o(seen.prio),
    .queue_depth_o(seen.depth), .busy_count_o(seen.busy_cnt),
    .drained_count_o(seen.drained), .total_submitted_o(seen.submitted),
    .total_completed_o(seen.completed), .total_cancelled_o(seen.cancelled),
    .total_rejected_full_o(seen.rejected_full), .total_failed_o(seen.failed)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // queue model state
  prq_pkg::entry_t pend [QDepth];
  int unsigned pend_cnt;
  bit          is_shut;
  logic [15:0] busy_model;
  logic [31:0] cnt_sub, cnt_ok, cnt_cancel, cnt_full, cnt_fail;
  logic [6:0]  depth_reg;

  outcome_t    pending_outcomes [$];
  int          mismatches = 0;
  int          gap_max = 6;

  function automatic int unsigned admit_limit();
    int unsigned lim;
    lim = depth_reg;
    if (lim == 0 || lim > QDepth) lim = QDepth;
    return lim;
  endfunction

  function automatic outcome_t queue_outcome(logic [1:0] cmd, logic [63:0] id,
                                             logic [7:0] kind, logic [7:0] prio,
                                             logic [1:0] fin);
    outcome_t o;
    int unsigned best;
    o = '0;
    case (cmd)
      prq_pkg::CmdSubmit: begin
        if (kind == 0 || id == 0) begin
          o.status = prq_pkg::StInvalid;
        end else if (is_shut) begin
          o.status = prq_pkg::StShutting;
          cnt_fail++;
        end else if (pend_cnt >= admit_limit()) begin
          o.status = prq_pkg::StFull;
          cnt_full++;
        end else begin
          pend[pend_cnt] = '{id: id, kind: kind, prio: prio};
          pend_cnt++;
          cnt_sub++;
          o.status = prq_pkg::StAccepted;
        end
      end
      prq_pkg::CmdPop: begin
        if (pend_cnt == 0) begin
          o.status = prq_pkg::StEmpty;
        end else begin
          best = 0;
          // strict less-than keeps the oldest on ties
          for (int unsigned i = 1; i < pend_cnt; i++)
            if (pend[i].prio < pend[best].prio) best = i;
          o.id = pend[best].id;
          o.kind = pend[best].kind;
          o.prio = pend[best].prio;
          for (int unsigned i = best; i + 1 < pend_cnt; i++) pend[i] = pend[i+1];
          pend_cnt--;
          if (busy_model != 16'hFFFF) busy_model++;
          o.status = prq_pkg::StIssued;
        end
      end
      prq_pkg::CmdFinish: begin
        if (busy_model > 0) busy_model--;
        if (fin == prq_pkg::FinOk) cnt_ok++;
        else if (fin == prq_pkg::FinCancel) cnt_cancel++;
        else cnt_fail++;
        o.status = prq_pkg::StFinished;
      end
      default: begin
        if (!is_shut) begin
          is_shut = 1'b1;
          o.drained = 7'(pend_cnt);
          cnt_fail += pend_cnt;
          pend_cnt = 0;
        end
        o.status = prq_pkg::StShutdownDone;
      end
    endcase
    o.depth = 7'(pend_cnt);
    o.busy_cnt = busy_model;
    o.submitted = cnt_sub;
    o.completed = cnt_ok;
    o.cancelled = cnt_cancel;
    o.rejected_full = cnt_full;
    o.failed = cnt_fail;
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %h", seen);
      end else begin
        outcome_t want;
        want = pending_outcomes.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h got %h", want, seen);
        end
      end
    end
  end

  task automatic send_command(logic [1:0] cmd, logic [63:0] id = 64'd1,
                              logic [7:0] kind = 8'd1, logic [7:0] prio = 8'd0,
                              logic [1:0] fin = prq_pkg::FinOk);
    int gap;
    outcome_t expected;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i <= cmd;
    asset_id_i <= id;
    asset_kind_i <= kind;
    priority_req_i <= prio;
    finish_status_i <= fin;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    expected = queue_outcome(cmd, id, kind, prio, fin);
    pending_outcomes = {pending_outcomes, expected};
  endtask

  // hold off until every transaction has reported back
  task automatic wait_quiet();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_depth(logic [6:0] value);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    depth_reg = value;
  endtask

  task automatic test_basic();
    send_command(prq_pkg::CmdFinish, , , , prq_pkg::FinOk);  // finish with nothing busy
    send_command(prq_pkg::CmdPop);                           // pop on empty queue
    send_command(prq_pkg::CmdSubmit, 64'd0, 8'd5, 8'd1);     // invalid id
    send_command(prq_pkg::CmdSubmit, 64'd7, 8'd0, 8'd1);     // invalid kind
    send_command(prq_pkg::CmdSubmit, '1, 8'hFF, 8'hFF);
    send_command(prq_pkg::CmdSubmit, 64'h1, 8'h1, 8'h00);
    send_command(prq_pkg::CmdSubmit, 64'hA5A5_5A5A_0F0F_F0F0, 8'h80, 8'h10);
    send_command(prq_pkg::CmdSubmit, 64'h5A5A_A5A5_F0F0_0F0F, 8'h7F, 8'h10);
    send_command(prq_pkg::CmdSubmit, 64'h8000_0000_0000_0000, 8'h01, 8'h00);
    repeat (5) send_command(prq_pkg::CmdPop);                // ties resolve to the oldest
    send_command(prq_pkg::CmdFinish, , , , prq_pkg::FinOk);
    send_command(prq_pkg::CmdFinish, , , , prq_pkg::FinCancel);
    send_command(prq_pkg::CmdFinish, , , , FinFailed);
    send_command(prq_pkg::CmdFinish, , , , FinUndefined);
    send_command(prq_pkg::CmdFinish, , , , prq_pkg::FinOk);
    send_command(prq_pkg::CmdFinish, , , , prq_pkg::FinOk);
  endtask

  task automatic fill_and_empty(logic [6:0] value);
    write_depth(value);
    for (int i = 0; i <= QDepth; i++)
      send_command(prq_pkg::CmdSubmit, {$urandom, $urandom} | 64'd1,
                   8'($urandom_range(1, 255)), 8'($urandom_range(0, 3)));
    while (pend_cnt != 0) send_command(prq_pkg::CmdPop);
  endtask

  task automatic test_depth_limits();
    fill_and_empty(7'd1);
    fill_and_empty(7'd2);
    fill_and_empty(7'd0);    // zero means the full queue
    fill_and_empty(7'd127);  // above the queue size saturates
    fill_and_empty(7'd64);
    fill_and_empty(7'd63);
  endtask

  task automatic test_random();
    logic [63:0] id;
    logic [7:0]  kind, prio;
    logic [6:0]  depths [7] = '{7'd1, 7'd3, 7'd8, 7'd0, 7'd64, 7'd100, 7'd127};
    int          pick;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 200 == 0) write_depth(depths[$urandom_range(0, 6)]);
      if (n == 300) wait_quiet();
      // stretches with no idling at all
      gap_max = ((n / 50) % 3 == 1) ? 0 : 6;
      id = {$urandom, $urandom};
      kind = 8'($urandom);
      prio = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      if ($urandom_range(0, 19) == 0) id = '0;
      if ($urandom_range(0, 19) == 0) kind = '0;
      pick = $urandom_range(0, 99);
      if (pick < 45) send_command(prq_pkg::CmdSubmit, id, kind, prio);
      else if (pick < 75) send_command(prq_pkg::CmdPop);
      else send_command(prq_pkg::CmdFinish, , , , 2'($urandom_range(0, 3)));
    end
    gap_max = 6;
  endtask

  task automatic test_shutdown();
    write_depth(7'd64);
    repeat (5)
      send_command(prq_pkg::CmdSubmit, {$urandom, $urandom} | 64'd1, 8'd4, 8'($urandom));
    send_command(prq_pkg::CmdShutdown);
    send_command(prq_pkg::CmdShutdown);                     // second one changes nothing
    send_command(prq_pkg::CmdSubmit, 64'd11, 8'd2, 8'd2);   // refused while shut down
    send_command(prq_pkg::CmdSubmit, 64'd0, 8'd2, 8'd2);    // invalid wins over shutdown
    send_command(prq_pkg::CmdPop);
    send_command(prq_pkg::CmdFinish, , , , prq_pkg::FinCancel);
  endtask

  initial begin
    pend_cnt = 0;
    is_shut = 1'b0;
    busy_model = '0;
    {cnt_sub, cnt_ok, cnt_cancel, cnt_full, cnt_fail} = '0;
    depth_reg = 7'd64;
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_basic();
    test_depth_limits();
    test_random();
    test_shutdown();
    wait_quiet();
    repeat (150) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("priority_request_queue_tb: PASS");
    end else begin
      $display("priority_request_queue_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("priority_request_queue_tb: FAIL");
    $finish;
  end

endmodule
